// ----- rtl/famhq_pkg.sv -----
`default_nettype none

package famhq_pkg;

	typedef logic signed [31:0] data_t;

	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_DEL_MAX = 2'd1;
	localparam logic [1:0] KIND_DEL_MIN = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT,
		OP_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    value;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/famhq_cell.sv -----
`default_nettype none

module famhq_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire famhq_pkg::cell_cmd_t cmd,
	input  wire famhq_pkg::data_t   left_value,
	input  wire logic               left_keep,
	input  wire logic               left_valid,
	input  wire famhq_pkg::data_t   left_scan,
	input  wire famhq_pkg::data_t   right_value,
	input  wire logic               right_valid,
	output famhq_pkg::data_t        value,
	output logic                    valid,
	output logic                    keep,
	output famhq_pkg::data_t        scan
);
	import famhq_pkg::*;

	data_t value_q;
	logic  valid_q;
	data_t scan_q;
	data_t value_d;
	logic  valid_d;

	// cell keeps its entry on insert when it is at least the new value
	assign keep = valid_q && (value_q >= cmd.value);

	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		case (cmd.op)
			OP_INSERT: begin
				if (!keep) begin
					value_d = left_keep ? cmd.value : left_value;
					valid_d = valid_q | left_valid;
				end
			end
			OP_SHIFT: begin
				value_d = right_value;
				valid_d = right_valid;
			end
			OP_DROP: begin
				// only the last occupied cell lets go
				valid_d = valid_q & right_valid;
			end
			default: begin
				value_d = value_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// value and tail scan carry need no reset
	always_ff @(posedge clk) begin
		value_q <= value_d;
		scan_q  <= valid_q ? value_q : left_scan;
	end

	assign value = value_q;
	assign valid = valid_q;
	assign scan  = scan_q;

endmodule

`default_nettype wire

// ----- rtl/famhq_ctrl.sv -----
`default_nettype none

module famhq_ctrl #(
	parameter int CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    kind,
	input  wire famhq_pkg::data_t              value,
	input  wire famhq_pkg::data_t              head_value,
	input  wire famhq_pkg::data_t              tail_value,
	output famhq_pkg::cell_cmd_t               cmd,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output famhq_pkg::data_t                   max_value,
	output famhq_pkg::data_t                   min_value,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	output logic                               is_empty,
	output logic [1:0]                         status
);
	import famhq_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SCAN_W = $clog2(CAPACITY);

	state_t              state_q;
	state_t              state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [SCAN_W-1:0]   scan_cnt_q;
	logic [1:0]          status_q;
	logic [1:0]          status_d;
	logic                accept;
	logic                full;
	logic                empty;
	logic                load_out;
	logic                out_valid_q;
	data_t               max_q;
	data_t               min_q;
	logic [CNT_W-1:0]    out_count_q;
	logic                out_empty_q;
	logic [1:0]          out_status_q;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		status_d  = status_q;
		cmd.op    = OP_HOLD;
		cmd.value = value;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d  = ST_SCAN;
					status_d = STATUS_OK;
					case (kind)
						KIND_INSERT: begin
							if (full) begin
								status_d = STATUS_FULL;
							end else begin
								cmd.op  = OP_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						KIND_DEL_MAX: begin
							if (empty) begin
								status_d = STATUS_EMPTY;
							end else begin
								cmd.op  = OP_SHIFT;
								count_d = count_q - 1'b1;
							end
						end
						KIND_DEL_MIN: begin
							if (empty) begin
								status_d = STATUS_EMPTY;
							end else begin
								cmd.op  = OP_DROP;
								count_d = count_q - 1'b1;
							end
						end
						default: begin
							cmd.op = OP_HOLD;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// tail carry must step through every cell to reach the far end
				if (scan_cnt_q == SCAN_W'(CAPACITY - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_cnt_q  <= '0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			status_q <= status_d;
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			max_q        <= empty ? '0 : head_value;
			min_q        <= empty ? '0 : tail_value;
			out_count_q  <= count_q;
			out_empty_q  <= empty;
			out_status_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign max_value   = max_q;
	assign min_value   = min_q;
	assign entry_count = out_count_q;
	assign is_empty    = out_empty_q;
	assign status      = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/five_ary_max_heap_queue_top.sv -----
`default_nettype none

// Max/min priority queue over signed 32-bit values, CAPACITY entries deep.
// Each input word asks for an insert, a delete of the largest or a delete of
// the smallest value; each gives one result word with the new largest and
// smallest values (zero when empty), the entry count, an empty flag and a
// status (full on a refused insert, empty on a delete with nothing stored).
// Values sit in a row of cells kept in descending order, so the largest is
// always in the first cell and every operation updates the whole row at once.
// The smallest value is carried down the row one cell per cycle, and the
// result word is offered once that carry has reached the last cell. With
// one word in flight at a time, a new word is taken only after the last
// word's result is loaded into the output register. A waiting result does
// not block acceptance of the next input word, but that word's result is
// held until the output register is free.
module five_ary_max_heap_queue_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    kind,
	input  wire famhq_pkg::data_t              value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output famhq_pkg::data_t                   max_value,
	output famhq_pkg::data_t                   min_value,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	output logic                               is_empty,
	output logic [1:0]                         status
);
	import famhq_pkg::*;

	cell_cmd_t             cmd;
	data_t                 cell_value [CAPACITY];
	data_t                 cell_scan  [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	logic [CAPACITY-1:0]   cell_keep;

	famhq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.head_value  (cell_value[0]),
		.tail_value  (cell_scan[CAPACITY-1]),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.max_value   (max_value),
		.min_value   (min_value),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.status      (status)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t left_value;
		data_t left_scan;
		data_t right_value;
		logic  left_keep;
		logic  left_valid;
		logic  right_valid;

		// the head cell sees an always-full neighbour, the tail an empty one
		if (i == 0) begin : g_head
			assign left_value = '0;
			assign left_scan  = '0;
			assign left_keep  = 1'b1;
			assign left_valid = 1'b1;
		end else begin : g_mid
			assign left_value = cell_value[i-1];
			assign left_scan  = cell_scan[i-1];
			assign left_keep  = cell_keep[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = '0;
			assign right_valid = 1'b0;
		end else begin : g_body
			assign right_value = cell_value[i+1];
			assign right_valid = cell_valid[i+1];
		end

		famhq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_value  (left_value),
			.left_keep   (left_keep),
			.left_valid  (left_valid),
			.left_scan   (left_scan),
			.right_value (right_value),
			.right_valid (right_valid),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.keep        (cell_keep[i]),
			.scan        (cell_scan[i])
		);
	end

endmodule

`default_nettype wire
